/* design/assert_macros.svh */
// Assertion macros for the checker, included by awc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked on the following clock edge.
`define AWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/awc_pkg.sv */
// ----------------------------------------------------------------------------
// Anagram word counter package
// Shared constants, codes and types of the anagram word counter.
// ----------------------------------------------------------------------------
package awc_pkg;

	localparam int unsigned MaxWordLenDflt = 16;
	localparam int unsigned CountWidthDflt = 16;
	localparam int unsigned TargetBytes    = 16;
	localparam int unsigned CfgDataWidth   = 64;
	localparam int unsigned CfgIndexWidth  = 2;
	localparam int unsigned LenWidth       = 5;
	localparam int unsigned CountOutWidth  = 16;
	localparam int unsigned CountWideWidth = 32;

	typedef logic [1:0]               func_t;
	typedef logic [7:0]               char_t;
	typedef logic [CountOutWidth-1:0] count_t;
	typedef logic [LenWidth-1:0]      len_t;

	// Item function codes.
	localparam func_t FUNC_CHAR    = 2'd0;
	localparam func_t FUNC_END     = 2'd1;
	localparam func_t FUNC_RESTART = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] REG_TARGET_LOW  = 2'd0;
	localparam logic [CfgIndexWidth-1:0] REG_TARGET_HIGH = 2'd1;
	localparam logic [CfgIndexWidth-1:0] REG_TARGET_LEN  = 2'd2;

	// Target word as seen by the datapath; len is already clamped.
	typedef struct packed {
		logic [TargetBytes-1:0][7:0] target;
		len_t                        len;
	} awc_cfg_t;

endpackage

/* design/awc_in_if.sv */
// ----------------------------------------------------------------------------
// Anagram word counter input channel
// Valid/ready channel carrying one character or control item per transfer.
// ----------------------------------------------------------------------------
interface awc_in_if;
	logic           valid;
	logic           ready;
	awc_pkg::func_t func;
	awc_pkg::char_t ch;

	modport source (output valid, output func, output ch, input ready);
	modport sink (input valid, input func, input ch, output ready);
endinterface

/* design/awc_out_if.sv */
// ----------------------------------------------------------------------------
// Anagram word counter result channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface awc_out_if;
	logic            valid;
	logic            ready;
	logic            word_done;
	logic            is_anagram;
	awc_pkg::count_t anagram_count;

	modport source (output valid, output word_done, output is_anagram,
		output anagram_count, input ready);
	modport sink (input valid, input word_done, input is_anagram,
		input anagram_count, output ready);
endinterface

/* design/awc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Anagram word counter configuration registers
// Holds the target word and its length, clamped to the supported maximum.
// ----------------------------------------------------------------------------
module awc_cfg_regs #(
	parameter int unsigned MAX_WORD_LEN = awc_pkg::MaxWordLenDflt
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [awc_pkg::CfgIndexWidth-1:0]     wr_index,
	input  logic [awc_pkg::CfgDataWidth-1:0]      wr_data,
	output awc_pkg::awc_cfg_t                     cfg
);
	import awc_pkg::*;

	logic [CfgDataWidth-1:0] low_q;
	logic [CfgDataWidth-1:0] high_q;
	len_t                    len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= '0;
			len_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_LOW:  low_q  <= wr_data;
				REG_TARGET_HIGH: high_q <= wr_data;
				REG_TARGET_LEN:  len_q  <= wr_data[LenWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.target = {high_q, low_q};
		cfg.len    = (len_q > LenWidth'(MAX_WORD_LEN)) ? LenWidth'(MAX_WORD_LEN) : len_q;
	end

endmodule

/* design/awc_claim.sv */
// ----------------------------------------------------------------------------
// Anagram word counter position claim
// Finds the lowest unclaimed position within the target length that holds the incoming byte.
// ----------------------------------------------------------------------------
module awc_claim #(
	parameter int unsigned MAX_WORD_LEN = awc_pkg::MaxWordLenDflt
) (
	input  awc_pkg::awc_cfg_t        cfg,
	input  logic [MAX_WORD_LEN-1:0]  claimed,
	input  awc_pkg::char_t           ch,
	output logic [MAX_WORD_LEN-1:0]  pick,
	output logic                     hit
);
	import awc_pkg::*;

	logic [MAX_WORD_LEN-1:0] cand;

	always_comb begin
		for (int p = 0; p < MAX_WORD_LEN; p++) begin
			cand[p] = !claimed[p] && (LenWidth'(p) < cfg.len) && (cfg.target[p] == ch);
		end
	end

	// Isolate the lowest set candidate bit.
	assign pick = cand & (~cand + MAX_WORD_LEN'(1));
	assign hit  = |cand;

endmodule

/* design/anagram_word_counter_top.sv */
// ----------------------------------------------------------------------------
// Anagram word counter
// Counts the words of a character stream that are anagrams of a target word.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result side is not stalled
// and returns one result for every item. An item is held in an input register,
// then the position claim, the word bookkeeping and the counter update are done
// into the result register, so a new item may follow in every cycle unless the
// result side stalls. The user must write the target word and its length
// through the configuration port while no item is in flight; the block does not enforce it.
module anagram_word_counter_top #(
	parameter int unsigned MAX_WORD_LEN = awc_pkg::MaxWordLenDflt,
	parameter int unsigned COUNT_WIDTH  = awc_pkg::CountWidthDflt
) (
	input  logic                               clk,
	input  logic                               arst_n,
	awc_in_if.sink                             chars,
	awc_out_if.source                          results,
	input  logic                               wr_en,
	input  logic [awc_pkg::CfgIndexWidth-1:0]  wr_index,
	input  logic [awc_pkg::CfgDataWidth-1:0]   wr_data
);
	import awc_pkg::*;

	awc_cfg_t cfg;

	logic  s1_valid;
	func_t func_s1;
	char_t ch_s1;
	logic  adv;

	logic [MAX_WORD_LEN-1:0] claimed_q, claimed_d;
	len_t                    seen_q, seen_d;
	logic                    failed_q, failed_d;
	logic [COUNT_WIDTH-1:0]  found_q, found_d;

	logic [MAX_WORD_LEN-1:0]   pick;
	logic                      hit;
	logic                      done_d, ana_d;
	logic [CountWideWidth-1:0] count_wide;

	logic   out_valid_q;
	logic   done_q, ana_q;
	count_t count_q;

	awc_cfg_regs #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	awc_claim #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_claim (
		.cfg     (cfg),
		.claimed (claimed_q),
		.ch      (ch_s1),
		.pick    (pick),
		.hit     (hit)
	);

	// The held item moves on whenever the result register is free or emptying.
	assign adv         = s1_valid && (!out_valid_q || results.ready);
	assign chars.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			s1_valid <= 1'b1;
		end else if (adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			func_s1 <= chars.func;
			ch_s1   <= chars.ch;
		end
	end

	always_comb begin
		claimed_d = claimed_q;
		seen_d    = seen_q;
		failed_d  = failed_q;
		found_d   = found_q;
		done_d    = 1'b0;
		ana_d     = 1'b0;
		case (func_s1)
			FUNC_CHAR: begin
				// A character beyond the target length or without a free match fails the word.
				if (seen_q >= cfg.len || !hit) begin
					failed_d = 1'b1;
				end else begin
					claimed_d = claimed_q | pick;
				end
				if (seen_q != '1) begin
					seen_d = seen_q + LenWidth'(1);
				end
			end
			FUNC_END: begin
				done_d = 1'b1;
				if (!failed_q && seen_q != '0 && seen_q == cfg.len) begin
					ana_d = 1'b1;
					if (found_q != '1) begin
						found_d = found_q + COUNT_WIDTH'(1);
					end
				end
				claimed_d = '0;
				seen_d    = '0;
				failed_d  = 1'b0;
			end
			FUNC_RESTART: begin
				claimed_d = '0;
				seen_d    = '0;
				failed_d  = 1'b0;
				found_d   = '0;
			end
			default: ;
		endcase
	end

	assign count_wide = CountWideWidth'(found_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
			seen_q    <= '0;
			failed_q  <= 1'b0;
			found_q   <= '0;
		end else if (adv) begin
			claimed_q <= claimed_d;
			seen_q    <= seen_d;
			failed_q  <= failed_d;
			found_q   <= found_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_q  <= done_d;
			ana_q   <= ana_d;
			count_q <= count_wide[CountOutWidth-1:0];
		end
	end

	assign results.valid         = out_valid_q;
	assign results.word_done     = done_q;
	assign results.is_anagram    = ana_q;
	assign results.anagram_count = count_q;

endmodule

/* design/awc_checker.sv */
// ----------------------------------------------------------------------------
// Anagram word counter checker
// Port-level checks of the anagram word counter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module awc_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   out_word_done,
	input logic                   out_is_anagram,
	input logic [15:0]            out_count
);

	// A result that is not taken keeps its contents.
	`AWC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word_done) && $stable(out_is_anagram) && $stable(out_count), "stalled result changed")

	// Only a closed word can be an anagram.
	`AWC_ASSERT_IMPLIES(a_ana_needs_done, clk, arst_n, out_valid && out_is_anagram, out_word_done, "anagram reported without word end")

	// With no result waiting, the input side is always open.
	`AWC_ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled with empty result register")

	// Every input transfer is followed by a valid result, checked after the input register and the result register.
	`AWC_ASSERT_IMPLIES(a_result_follows, clk, arst_n, in_valid && in_ready, ##2 out_valid, "no result after input transfer")

endmodule

bind anagram_word_counter_top awc_checker u_awc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (chars.valid),
	.in_ready       (chars.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_word_done  (results.word_done),
	.out_is_anagram (results.is_anagram),
	.out_count      (results.anagram_count)
);
